// ===== src/ura_pkg.sv =====
// ----------------------------------------------------------------------------
// ura_pkg: shared types and constants for unsigned_to_radix_ascii
// Transfer structs, controller commands and status, state encoding and the
// digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package ura_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	// Quotient bits resolved per divider cycle.
	localparam int STEP_BITS = 8;

	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [7:0] ERROR_CHAR = 8'h00;
	localparam logic [4:0] RADIX_MIN  = 5'd2;
	localparam logic [4:0] RADIX_MAX  = 5'd16;

	typedef struct packed {
		logic [31:0] value;
		logic [4:0]  radix;
		logic [7:0]  sign_char;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last;
		logic       bad_radix;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_EMIT_SIGN,
		ST_EMIT_DIGITS
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic emit_err;
		logic emit_sign;
		logic emit_digit;
	} cmd_t;

	typedef struct packed {
		logic radix_ok;
		logic sign_en;
		logic div_done;
		logic digit_last;
	} status_t;

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		logic [7:0] base;
		base = (d < 4'd10) ? 8'h30 : 8'h37;
		return base + {4'b0000, d};
	endfunction

endpackage

`default_nettype wire

// ===== src/ura_ctrl.sv =====
// ----------------------------------------------------------------------------
// ura_ctrl: sequencing controller
// Steps the datapath through division, sign output and digit output.
// ----------------------------------------------------------------------------
`default_nettype none

module ura_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire ura_pkg::status_t status,
	output ura_pkg::cmd_t         cmd,
	output logic                  busy
);

	ura_pkg::state_t state_q;
	ura_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ura_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		busy       = 1'b1;
		case (state_q)
			ura_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (status.radix_ok) begin
						cmd.load   = 1'b1;
						state_next = ura_pkg::ST_DIVIDE;
					end else begin
						// A bad radix answers at once and leaves the block idle.
						cmd.emit_err = 1'b1;
					end
				end
			end
			ura_pkg::ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (status.div_done) begin
					state_next = status.sign_en ? ura_pkg::ST_EMIT_SIGN
					                            : ura_pkg::ST_EMIT_DIGITS;
				end
			end
			ura_pkg::ST_EMIT_SIGN: begin
				cmd.emit_sign = 1'b1;
				state_next    = ura_pkg::ST_EMIT_DIGITS;
			end
			ura_pkg::ST_EMIT_DIGITS: begin
				cmd.emit_digit = 1'b1;
				if (status.digit_last) begin
					state_next = ura_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = ura_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/ura_datapath.sv =====
// ----------------------------------------------------------------------------
// ura_datapath: divider, digit store and output stage
// Divides the working quotient by the radix several bits per cycle, stores
// each remainder digit and reads the digits back most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module ura_datapath #(
	parameter int VALUE_WIDTH = ura_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ura_pkg::in_item_t  item,
	input  wire ura_pkg::cmd_t      cmd,
	output ura_pkg::status_t        status,
	output logic                    strobe,
	output ura_pkg::out_item_t      result
);

	localparam int SB     = ura_pkg::STEP_BITS;
	localparam int PW     = ((VALUE_WIDTH + SB - 1) / SB) * SB;
	localparam int NCHUNK = PW / SB;
	localparam int KW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
	localparam int AW     = $clog2(VALUE_WIDTH);
	localparam int CW     = $clog2(VALUE_WIDTH + 1);
	localparam logic [PW-1:0] VMASK = {PW{1'b1}} >> (PW - VALUE_WIDTH);

	logic [PW-1:0] work_q;
	logic [4:0]    radix_q;
	logic [7:0]    sign_q;
	logic [3:0]    rem_q;
	logic [KW-1:0] chunk_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] rd_idx_q;

	logic [3:0] mem [VALUE_WIDTH];
	logic [3:0] rdata_s1;

	logic       strobe_s1;
	logic       digit_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       bad_s1;

	logic [63:0]   val_wide;
	logic [PW-1:0] val_init;
	logic [3:0]    rem_next;
	logic [SB-1:0] qbits;
	logic [PW-1:0] work_next;
	logic          chunk_last;

	assign val_wide = {32'b0, item.value};
	assign val_init = val_wide[PW-1:0] & VMASK;

	// Restoring division over the top bits of the working word; the partial
	// remainder stays below the radix, so each step is a 5-bit compare.
	always_comb begin
		logic [4:0] t;
		logic [3:0] r;
		r = rem_q;
		qbits = '0;
		for (int k = 0; k < SB; k++) begin
			t = {r, work_q[PW-1-k]};
			if (t >= radix_q) begin
				qbits[SB-1-k] = 1'b1;
				t = t - radix_q;
			end
			r = t[3:0];
		end
		rem_next = r;
	end

	generate
		if (PW > SB) begin : g_shift
			assign work_next = {work_q[PW-SB-1:0], qbits};
		end else begin : g_single
			assign work_next = qbits;
		end
	endgenerate

	assign chunk_last = (chunk_q == KW'(NCHUNK - 1));

	assign status.radix_ok   = (item.radix >= ura_pkg::RADIX_MIN) &&
	                           (item.radix <= ura_pkg::RADIX_MAX);
	assign status.sign_en    = (sign_q != ura_pkg::SPACE_CHAR);
	assign status.div_done   = chunk_last && (work_next == '0);
	assign status.digit_last = (rd_idx_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_q   <= '0;
			rem_q    <= '0;
			chunk_q  <= '0;
			cnt_q    <= '0;
			rd_idx_q <= '0;
		end else begin
			if (cmd.load) begin
				work_q  <= val_init;
				rem_q   <= '0;
				chunk_q <= '0;
				cnt_q   <= '0;
			end else if (cmd.div_step) begin
				work_q <= work_next;
				if (chunk_last) begin
					rem_q    <= '0;
					chunk_q  <= '0;
					cnt_q    <= cnt_q + 1'b1;
					rd_idx_q <= cnt_q[AW-1:0];
				end else begin
					rem_q   <= rem_next;
					chunk_q <= chunk_q + 1'b1;
				end
			end else if (cmd.emit_digit) begin
				rd_idx_q <= rd_idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			radix_q <= item.radix;
			sign_q  <= item.sign_char;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_step && chunk_last) begin
			mem[cnt_q[AW-1:0]] <= rem_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_digit) begin
			rdata_s1 <= mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_s1 <= 1'b0;
		end else begin
			strobe_s1 <= cmd.emit_err | cmd.emit_sign | cmd.emit_digit;
		end
	end

	always_ff @(posedge clk) begin
		digit_s1 <= cmd.emit_digit;
		if (cmd.emit_err) begin
			char_s1 <= ura_pkg::ERROR_CHAR;
			last_s1 <= 1'b1;
			bad_s1  <= 1'b1;
		end else if (cmd.emit_sign) begin
			char_s1 <= sign_q;
			last_s1 <= 1'b0;
			bad_s1  <= 1'b0;
		end else if (cmd.emit_digit) begin
			last_s1 <= (rd_idx_q == '0);
			bad_s1  <= 1'b0;
		end
	end

	assign strobe           = strobe_s1;
	assign result.out_char  = digit_s1 ? ura_pkg::hex_char(rdata_s1) : char_s1;
	assign result.last      = last_s1;
	assign result.bad_radix = bad_s1;

endmodule

`default_nettype wire

// ===== src/unsigned_to_radix_ascii.sv =====
// ----------------------------------------------------------------------------
// unsigned_to_radix_ascii: unsigned value to ASCII text in radix 2 to 16
// Top level joining the sequencing controller and the divider datapath.
// ----------------------------------------------------------------------------
// A conversion is accepted when start is high while busy is low. Each
// character then appears on result for one cycle with strobe high: first the
// sign character unless it is a space, then the digits most significant
// first, the final one with last set. The receiver cannot stall, so every
// character must be taken in the cycle it is shown. Each digit is found
// by the divider, which resolves eight quotient bits per cycle; then the
// sign is shown and each digit is read back from the digit store. A
// conversion keeps busy high through division, sign and digit output,
// and the final character is shown in the first cycle with busy low again.
// A radix outside 2 to 16 gives a single error character in the next cycle
// and leaves busy low.
`default_nettype none

module unsigned_to_radix_ascii #(
	parameter int VALUE_WIDTH = ura_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire ura_pkg::in_item_t  item,
	output logic                    strobe,
	output ura_pkg::out_item_t      result
);

	ura_pkg::cmd_t    cmd;
	ura_pkg::status_t status;

	ura_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	ura_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.strobe (strobe),
		.result (result)
	);

	// A bad radix answers with exactly one error character in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (item.radix < ura_pkg::RADIX_MIN ||
		                    item.radix > ura_pkg::RADIX_MAX))
		|=> (strobe && result.bad_radix && result.last &&
		     result.out_char == ura_pkg::ERROR_CHAR))
		else $error("bad radix did not produce a single error transfer");

	// A valid conversion starts the divider, so no character follows at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.radix >= ura_pkg::RADIX_MIN &&
		 item.radix <= ura_pkg::RADIX_MAX)
		|=> (busy && !(strobe && result.bad_radix)))
		else $error("valid conversion did not enter the divider");

	// Error flags only ever come on a final character.
	assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.bad_radix) |-> result.last)
		else $error("error transfer without last");

	// A character is never shown while a conversion is still dividing.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !strobe)
		else $error("transfer during division");

endmodule

`default_nettype wire

// ===== test/unsigned_to_radix_ascii_test.sv =====
// ----------------------------------------------------------------------------
// unsigned_to_radix_ascii_test: self-checking bench for radix ASCII conversion
// A short directed table covers zero, full-scale values, every radix edge,
// bad radix codes and unusual sign characters. A random phase follows. Every
// strobed character is compared in order against a queue of expected text.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module unsigned_to_radix_ascii_test;

	localparam int RANDOM_ITEMS = 135;
	localparam int IDLE_PERCENT = 36;
	localparam int BAD_RADIX_PERCENT = 15;
	localparam int QUIET_FIRST = 60;
	localparam int QUIET_LAST = 100;
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT = 300000;
	localparam logic [7:0] SPACE_CHAR = ura_pkg::SPACE_CHAR;

	typedef enum {
		CHECK_PREDICTED,
		CHECK_TEXT,
		CHECK_ERROR
	} check_kind_t;

	typedef struct {
		logic [31:0] value;
		logic [4:0]  radix;
		logic [7:0]  sign_char;
		check_kind_t kind;
		string       text;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	ura_pkg::in_item_t item;
	logic strobe;
	ura_pkg::out_item_t result;

	ura_pkg::out_item_t expected_chars[$];
	ura_pkg::out_item_t oldest_char;
	string glyphs = "0123456789ABCDEF";
	int failures = 0;
	int cycle_count = 0;

	// Text rows use the literal string, error rows a single error character, the rest the predictor.
	stim_row_t directed_rows[$] = '{
		'{32'd0,          5'd10, SPACE_CHAR, CHECK_TEXT, "0"},
		'{32'd0,          5'd2,  8'h2B,      CHECK_TEXT, "+0"},
		'{32'hFFFFFFFF,   5'd16, SPACE_CHAR, CHECK_TEXT, "FFFFFFFF"},
		'{32'hFFFFFFFF,   5'd2,  SPACE_CHAR, CHECK_TEXT, "11111111111111111111111111111111"},
		'{32'hFFFFFFFF,   5'd10, 8'h2D,      CHECK_TEXT, "-4294967295"},
		'{32'hFFFFFFFF,   5'd8,  SPACE_CHAR, CHECK_TEXT, "37777777777"},
		'{32'hDEADBEEF,   5'd16, SPACE_CHAR, CHECK_TEXT, "DEADBEEF"},
		'{32'd1,          5'd2,  SPACE_CHAR, CHECK_TEXT, "1"},
		'{32'd15,         5'd16, SPACE_CHAR, CHECK_TEXT, "F"},
		'{32'd16,         5'd16, SPACE_CHAR, CHECK_TEXT, "10"},
		'{32'd12345,      5'd0,  SPACE_CHAR, CHECK_ERROR, ""},
		'{32'd12345,      5'd1,  8'h2D,      CHECK_ERROR, ""},
		'{32'hFFFFFFFF,   5'd17, 8'h2B,      CHECK_ERROR, ""},
		'{32'd0,          5'd31, 8'hFF,      CHECK_ERROR, ""},
		'{32'd10,         5'd10, SPACE_CHAR, CHECK_TEXT, "10"},
		'{32'd255,        5'd3,  SPACE_CHAR, CHECK_PREDICTED, ""},
		'{32'h80000000,   5'd2,  8'h00,      CHECK_PREDICTED, ""},
		'{32'h7FFFFFFF,   5'd5,  8'hFF,      CHECK_PREDICTED, ""},
		'{32'h12345678,   5'd6,  8'h2D,      CHECK_PREDICTED, ""},
		'{32'hCAFEF00D,   5'd7,  SPACE_CHAR, CHECK_PREDICTED, ""},
		'{32'h0BADF00D,   5'd9,  8'h41,      CHECK_PREDICTED, ""},
		'{32'hA5A5A5A5,   5'd11, SPACE_CHAR, CHECK_PREDICTED, ""},
		'{32'h5A5A5A5A,   5'd12, 8'h2B,      CHECK_PREDICTED, ""},
		'{32'hFEDCBA98,   5'd13, SPACE_CHAR, CHECK_PREDICTED, ""},
		'{32'h00C0FFEE,   5'd15, 8'h7E,      CHECK_PREDICTED, ""}
	};

	unsigned_to_radix_ascii uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.strobe(strobe),
		.result(result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic push_char(input logic [7:0] ch, input logic is_last, input logic is_bad);
		ura_pkg::out_item_t entry;
		entry.out_char = ch;
		entry.last = is_last;
		entry.bad_radix = is_bad;
		expected_chars.push_back(entry);
	endtask

	// Repeated division leaves the digits least significant first.
	task automatic predict_conversion(input ura_pkg::in_item_t it);
		logic [3:0]  digits [0:31];
		logic [31:0] rest;
		logic [31:0] remainder;
		logic [31:0] base;
		int          count;
		int          i;
		base = {27'd0, it.radix};
		if (it.radix < ura_pkg::RADIX_MIN || it.radix > ura_pkg::RADIX_MAX) begin
			push_char(ura_pkg::ERROR_CHAR, 1'b1, 1'b1);
			return;
		end
		rest = it.value;
		count = 0;
		do begin
			remainder = rest % base;
			digits[count] = remainder[3:0];
			count++;
			rest = rest / base;
		end while (rest != 32'd0);
		if (it.sign_char != SPACE_CHAR)
			push_char(it.sign_char, 1'b0, 1'b0);
		for (i = count - 1; i >= 0; i--)
			push_char(glyphs[digits[i]], i == 0, 1'b0);
	endtask

	task automatic send_conversion(input ura_pkg::in_item_t it, input bit allow_idle,
			input check_kind_t kind, input string text);
		int i;
		if (allow_idle) begin
			while ($urandom_range(99) < IDLE_PERCENT) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		// The transfer happened at this edge; record what it must produce.
		case (kind)
			CHECK_PREDICTED: begin
				predict_conversion(it);
			end
			CHECK_ERROR: begin
				push_char(ura_pkg::ERROR_CHAR, 1'b1, 1'b1);
			end
			default: begin
				for (i = 0; i < text.len(); i++)
					push_char(text[i], i == text.len() - 1, 1'b0);
			end
		endcase
	endtask

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (expected_chars.size() == 0) begin
				$error("unexpected result: out_char %h last %b bad_radix %b",
					result.out_char, result.last, result.bad_radix);
				failures++;
			end else begin
				oldest_char = expected_chars.pop_front();
				if (result.out_char !== oldest_char.out_char) begin
					$error("out_char: expected %h, actual %h",
						oldest_char.out_char, result.out_char);
					failures++;
				end
				if (result.last !== oldest_char.last) begin
					$error("last: expected %b, actual %b", oldest_char.last, result.last);
					failures++;
				end
				if (result.bad_radix !== oldest_char.bad_radix) begin
					$error("bad_radix: expected %b, actual %b",
						oldest_char.bad_radix, result.bad_radix);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		ura_pkg::in_item_t next_item;
		int                n;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			next_item.value = directed_rows[r].value;
			next_item.radix = directed_rows[r].radix;
			next_item.sign_char = directed_rows[r].sign_char;
			send_conversion(next_item, 1'b1, directed_rows[r].kind, directed_rows[r].text);
		end

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			case ($urandom_range(3))
				0: next_item.value = $urandom;
				1: next_item.value = $urandom_range(0, 255);
				2: next_item.value = $urandom >> $urandom_range(0, 31);
				default: next_item.value = $urandom_range(1) ? 32'hFFFFFFFF : 32'd0;
			endcase
			if ($urandom_range(99) < BAD_RADIX_PERCENT)
				next_item.radix = $urandom_range(1) ? 5'($urandom_range(0, 1))
					: 5'($urandom_range(17, 31));
			else
				next_item.radix = 5'($urandom_range(2, 16));
			next_item.sign_char = $urandom_range(1) ? SPACE_CHAR : 8'($urandom_range(0, 255));
			// A block of items is sent back to back with start held high throughout.
			send_conversion(next_item, !(n >= QUIET_FIRST && n < QUIET_LAST),
				CHECK_PREDICTED, "");
		end

		start <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
